// File: sv/potn_pkg.sv
// Package for the point-over-triangle normal unit: shared constants and types.
// Used by potn_norm_search and point_over_triangle_normal_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package potn_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 16;
  // Bits of the scaled normal magnitude (0..127).
  localparam int Q_BITS = 7;
  // Number of input fields in one beat.
  localparam int IN_FIELDS = 11;
  // Output beat width: inside flag plus three 8-bit components, padded to bytes.
  localparam int OUT_W = 32;
  localparam int NORM_W = 8;

  // Flags that travel beside the normal search.
  typedef struct packed {
    logic       hit;
    logic       nonzero;
    logic [2:0] neg;
  } potn_flags_t;

endpackage : potn_pkg
`default_nettype wire

// File: sv/potn_norm_search.sv
// Bit-per-stage search for the scaled normal magnitudes of three lanes.
// Depends on potn_pkg for Q_BITS and the flag struct.
`timescale 1ns / 1ps
`default_nettype none
module potn_norm_search #(
  parameter int LW = 84
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire [LW-1:0]              sum_i,
  input  wire [2:0][LW-1:0]         rhs_i,
  input  potn_pkg::potn_flags_t     flags_i,
  output logic                      valid_o,
  output logic [2:0][potn_pkg::Q_BITS-1:0] q_o,
  output potn_pkg::potn_flags_t     flags_o
);
  import potn_pkg::*;

  logic                    vld_q  [Q_BITS];
  logic [LW-1:0]           sum_q  [Q_BITS];
  potn_flags_t             flg_q  [Q_BITS];
  logic [2:0][LW-1:0]      rhs_q  [Q_BITS];
  logic [2:0][LW-1:0]      acc_q  [Q_BITS];
  logic [2:0][LW-1:0]      qs_q   [Q_BITS];
  logic [2:0][Q_BITS-1:0]  qv_q   [Q_BITS];

  // Each stage settles one bit of q, most significant first. It keeps
  // q^2*S and q*S so that trying the next bit needs only shifts and adds.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int B = Q_BITS - 1 - k;

    logic                   pv;
    logic [LW-1:0]          ps;
    potn_flags_t            pf;
    logic [2:0][LW-1:0]     pr;
    logic [2:0][LW-1:0]     pa;
    logic [2:0][LW-1:0]     pq;
    logic [2:0][Q_BITS-1:0] pqv;

    if (k == 0) begin : g_first
      assign pv  = valid_i;
      assign ps  = sum_i;
      assign pf  = flags_i;
      assign pr  = rhs_i;
      assign pa  = '0;
      assign pq  = '0;
      assign pqv = '0;
    end else begin : g_next
      assign pv  = vld_q[k-1];
      assign ps  = sum_q[k-1];
      assign pf  = flg_q[k-1];
      assign pr  = rhs_q[k-1];
      assign pa  = acc_q[k-1];
      assign pq  = qs_q[k-1];
      assign pqv = qv_q[k-1];
    end

    // Valid bit of this stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    // Trial of bit B in each lane.
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [LW-1:0] trial;
      logic          take;
      assign trial = pa[l] + (pq[l] << (B + 1)) + (ps << (2 * B));
      assign take  = (trial <= pr[l]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          acc_q[k][l] <= take ? trial : pa[l];
          qs_q[k][l]  <= take ? (pq[l] + (ps << B)) : pq[l];
          qv_q[k][l]  <= pqv[l] | (take ? (Q_BITS'(1) << B) : '0);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[k] <= ps;
        flg_q[k] <= pf;
        rhs_q[k] <= pr;
      end
    end
  end

  assign valid_o = vld_q[Q_BITS-1];
  assign q_o     = qv_q[Q_BITS-1];
  assign flags_o = flg_q[Q_BITS-1];

endmodule : potn_norm_search
`default_nettype wire

// File: sv/point_over_triangle_normal_unit.sv
// Top level of the point-over-triangle normal unit: edge tests, cross product,
// squared length and output packing. Depends on potn_pkg and potn_norm_search.
`timescale 1ns / 1ps
`default_nettype none
// Tests whether a point (x, z) lies inside a triangle projected onto the XZ
// plane, with inclusive edge tests, and on a hit gives the triangle normal
// scaled to length 127, each component truncated toward zero; the normal is
// zero when the point misses or the triangle is degenerate. The unit takes
// one beat every cycle while no result waits on m_axis_tready and gives one
// result beat per input beat, in order, through six stages of differences,
// products, cross product and squared length, seven stages that settle one
// bit each of the scaled magnitudes, and the output register. The whole
// pipeline advances together and holds while a result waits on m_axis_tready.
module point_over_triangle_normal_unit #(
  parameter int COORD_BITS = potn_pkg::COORD_BITS_DEF
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           s_axis_tvalid,
  output logic                                          s_axis_tready,
  // point_x, point_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, from bit 0
  input  wire [((potn_pkg::IN_FIELDS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  wire                                           m_axis_tready,
  // inside_res, normal_x, normal_y, normal_z, from bit 0; zero padding above
  output logic [potn_pkg::OUT_W-1:0]                    m_axis_tdata
);
  import potn_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int D  = W + 1;        // coordinate difference
  localparam int P  = 2 * D;        // product of two differences
  localparam int NW = P + 1;        // cross product term
  localparam int LW = 4 * D + 16;   // squared-length arithmetic

  // Pipeline advances when the output register is free or being emptied.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Field extraction.
  logic signed [W-1:0] f [IN_FIELDS];
  for (genvar i = 0; i < IN_FIELDS; i++) begin : g_field
    assign f[i] = s_axis_tdata[i*W +: W];
  end

  // Stage 1: coordinate differences.
  logic [6:1] v_q;
  logic signed [D-1:0] d_q [14];
  logic signed [D-1:0] d_d [14];
  always_comb begin
    d_d[0]  = D'(f[5])  - D'(f[2]);   // bx-ax
    d_d[1]  = D'(f[6])  - D'(f[3]);   // by-ay
    d_d[2]  = D'(f[7])  - D'(f[4]);   // bz-az
    d_d[3]  = D'(f[8])  - D'(f[5]);   // cx-bx
    d_d[4]  = D'(f[9])  - D'(f[6]);   // cy-by
    d_d[5]  = D'(f[10]) - D'(f[7]);   // cz-bz
    d_d[6]  = D'(f[2])  - D'(f[8]);   // ax-cx
    d_d[7]  = D'(f[4])  - D'(f[10]);  // az-cz
    d_d[8]  = D'(f[0])  - D'(f[5]);   // px-bx
    d_d[9]  = D'(f[1])  - D'(f[7]);   // pz-bz
    d_d[10] = D'(f[1])  - D'(f[10]);  // pz-cz
    d_d[11] = D'(f[0])  - D'(f[8]);   // px-cx
    d_d[12] = D'(f[1])  - D'(f[4]);   // pz-az
    d_d[13] = D'(f[0])  - D'(f[2]);   // px-ax
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= d_d;
    end
  end

  // Stage 2: the twelve products of the edge tests and cross product.
  logic signed [P-1:0] p_q [12];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= P'(d_q[2]) * P'(d_q[8]);   // edge 1, left
      p_q[1]  <= P'(d_q[0]) * P'(d_q[9]);   // edge 1, right
      p_q[2]  <= P'(d_q[3]) * P'(d_q[10]);  // edge 2, left
      p_q[3]  <= P'(d_q[5]) * P'(d_q[11]);  // edge 2, right
      p_q[4]  <= P'(d_q[6]) * P'(d_q[12]);  // edge 3, left
      p_q[5]  <= P'(d_q[7]) * P'(d_q[13]);  // edge 3, right
      p_q[6]  <= P'(d_q[1]) * P'(d_q[5]);
      p_q[7]  <= P'(d_q[2]) * P'(d_q[4]);
      p_q[8]  <= P'(d_q[2]) * P'(d_q[3]);
      p_q[9]  <= P'(d_q[0]) * P'(d_q[5]);
      p_q[10] <= P'(d_q[0]) * P'(d_q[4]);
      p_q[11] <= P'(d_q[1]) * P'(d_q[3]);
    end
  end

  // Stage 3: edge decisions and normal magnitudes with their signs.
  logic signed [NW-1:0] n_d [3];
  logic                 inside_q3;
  logic [2:0]           neg_q3;
  logic [P-1:0]         mag_q [3];
  assign n_d[0] = NW'(p_q[6])  - NW'(p_q[7]);
  assign n_d[1] = NW'(p_q[8])  - NW'(p_q[9]);
  assign n_d[2] = NW'(p_q[10]) - NW'(p_q[11]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q3 <= (NW'(p_q[0]) - NW'(p_q[1]) >= 0) && (p_q[2] <= p_q[3]) &&
                   (p_q[4] <= p_q[5]);
      for (int l = 0; l < 3; l++) begin
        neg_q3[l] <= n_d[l][NW-1];
        mag_q[l]  <= n_d[l][NW-1] ? P'(-n_d[l]) : P'(n_d[l]);
      end
    end
  end

  // Stage 4: partial products of each squared magnitude.
  logic [P-1:0] ll_q [3];
  logic [P-1:0] lh_q [3];
  logic [P-1:0] hh_q [3];
  logic         inside_q4;
  logic [2:0]   neg_q4;
  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q4 <= inside_q3;
      neg_q4    <= neg_q3;
      for (int l = 0; l < 3; l++) begin
        ll_q[l] <= P'(mag_q[l][D-1:0]) * P'(mag_q[l][D-1:0]);
        lh_q[l] <= P'(mag_q[l][D-1:0]) * P'(mag_q[l][P-1:D]);
        hh_q[l] <= P'(mag_q[l][P-1:D]) * P'(mag_q[l][P-1:D]);
      end
    end
  end

  // Stage 5: squared magnitudes.
  logic [2*P-1:0] sq_q [3];
  logic           inside_q5;
  logic [2:0]     neg_q5;
  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q5 <= inside_q4;
      neg_q5    <= neg_q4;
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= ((2*P)'(hh_q[l]) << P) + ((2*P)'(lh_q[l]) << (D + 1)) +
                   (2*P)'(ll_q[l]);
      end
    end
  end

  // Stage 6: squared length and the right-hand sides 127^2 * N^2,
  // with 127^2 = 2^14 - 2^8 + 1.
  logic [LW-1:0]      sum_q;
  logic [2:0][LW-1:0] rhs_q;
  potn_flags_t        flg_q6;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);
      for (int l = 0; l < 3; l++) begin
        rhs_q[l] <= (LW'(sq_q[l]) << 14) - (LW'(sq_q[l]) << 8) + LW'(sq_q[l]);
      end
      flg_q6.hit     <= inside_q5;
      flg_q6.nonzero <= (sq_q[0] != '0) || (sq_q[1] != '0) || (sq_q[2] != '0);
      flg_q6.neg     <= neg_q5;
    end
  end

  // Stages 7 to 13: magnitude search.
  logic                   srch_v;
  logic [2:0][Q_BITS-1:0] srch_q;
  potn_flags_t            srch_f;
  potn_norm_search #(
    .LW (LW)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[6]),
    .sum_i   (sum_q),
    .rhs_i   (rhs_q),
    .flags_i (flg_q6),
    .valid_o (srch_v),
    .q_o     (srch_q),
    .flags_o (srch_f)
  );

  // Output register: apply signs and clear the normal on a miss or a zero normal.
  logic [NORM_W-1:0] comp [3];
  logic              keep;
  assign keep = srch_f.hit && srch_f.nonzero;
  for (genvar l = 0; l < 3; l++) begin : g_comp
    logic [NORM_W-1:0] mag;
    assign mag     = NORM_W'(srch_q[l]);
    assign comp[l] = !keep ? '0 : (srch_f.neg[l] ? NORM_W'(-mag) : mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= srch_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= OUT_W'({comp[2], comp[1], comp[0], srch_f.hit});
    end
  end

`ifndef SYNTHESIS
  // Input is taken exactly when the pipeline may advance.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow the pipeline enable");

  // A miss carries a zero normal.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:1] == '0))
    else $error("normal given for a point outside the triangle");

  // Components stay within -127..127.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:1] != 8'h80 && m_axis_tdata[16:9] != 8'h80 &&
                       m_axis_tdata[24:17] != 8'h80))
    else $error("normal component out of range");
`endif

endmodule : point_over_triangle_normal_unit
`default_nettype wire

// File: tb/sv/point_over_triangle_normal_unit_tb.sv
// Testbench for point_over_triangle_normal_unit: directed table, then random beats,
// all checked against a local predictor. Depends on potn_pkg and the unit RTL.
`timescale 1ns / 1ps
module point_over_triangle_normal_unit_tb;
  import potn_pkg::*;

  localparam int CB      = 16;
  localparam int IN_W    = ((IN_FIELDS * CB + 7) / 8) * 8;
  localparam int N_RAND  = 1280;
  localparam int QUIET   = 200;   // final random beats with no idling
  localparam int LATENCY = 14;

  typedef shortint coords_t [IN_FIELDS];

  typedef struct {
    coords_t     f;
    bit          typed;
    logic [31:0] want;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // point_x, point_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, from bit 0
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // inside_res, normal_x, normal_y, normal_z, from bit 0
  logic [OUT_W-1:0]  m_axis_tdata;

  logic [31:0] normal_q[$];
  int          errors = 0;
  bit          hold_off = 1'b0;
  bit          quiet = 1'b0;
  int          sent = 0;
  row_t        rows[$];

  point_over_triangle_normal_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // Scaled magnitude: the largest q in 0..127 with q^2 * s <= 127^2 * n^2.
  function automatic logic [7:0] scaled_comp(longint n, logic [127:0] s);
    logic [127:0] mag, rhs;
    int q;
    mag = (n < 0) ? -n : n;
    rhs = mag * mag * 128'd16129;
    q = 127;
    while (q > 0 && (s * q * q) > rhs) q--;
    return (n < 0) ? 8'(-q) : 8'(q);
  endfunction

  // Edge tests on XZ and the normalised cross product on a hit.
  function automatic logic [31:0] contact_normal(coords_t f);
    longint px, pz, ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz;
    logic [127:0] ssum, ux, uy, uz;
    logic [7:0] ox, oy, oz;
    bit hit;
    px = f[0]; pz = f[1]; ax = f[2]; ay = f[3]; az = f[4];
    bx = f[5]; by = f[6]; bz = f[7]; cx = f[8]; cy = f[9]; cz = f[10];
    ox = 0; oy = 0; oz = 0;
    hit = ((bz - az) * (px - bx) - (bx - ax) * (pz - bz) >= 0) &&
          ((cx - bx) * (pz - cz) <= (cz - bz) * (px - cx)) &&
          ((ax - cx) * (pz - az) <= (az - cz) * (px - ax));
    if (hit) begin
      nx = (by - ay) * (cz - bz) - (bz - az) * (cy - by);
      ny = (bz - az) * (cx - bx) - (bx - ax) * (cz - bz);
      nz = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
      if (nx != 0 || ny != 0 || nz != 0) begin
        ux = (nx < 0) ? -nx : nx;
        uy = (ny < 0) ? -ny : ny;
        uz = (nz < 0) ? -nz : nz;
        ssum = ux * ux + uy * uy + uz * uz;
        ox = scaled_comp(nx, ssum);
        oy = scaled_comp(ny, ssum);
        oz = scaled_comp(nz, ssum);
      end
    end
    return {7'b0, oz, oy, ox, hit};
  endfunction

  // Mostly well-formed: a triangle with the point at its centroid or a vertex,
  // winding chosen at random; the rest full-range noise.
  function automatic coords_t random_triangle();
    coords_t f;
    int span, k, t;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      foreach (f[i]) f[i] = shortint'($urandom());
    end else begin
      span = (k < 8) ? 200 : 32767;
      for (int i = 2; i < IN_FIELDS; i++) f[i] = shortint'($urandom_range(0, 2 * span) - span);
      if ($urandom_range(0, 1)) begin
        for (int i = 5; i < 8; i++) begin
          t = f[i]; f[i] = f[i + 3]; f[i + 3] = shortint'(t);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        f[0] = f[2]; f[1] = f[4];
      end else begin
        f[0] = shortint'((int'(f[2]) + f[5] + f[8]) / 3);
        f[1] = shortint'((int'(f[4]) + f[7] + f[10]) / 3);
      end
    end
    return f;
  endfunction

  task automatic send_beat(coords_t f);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    for (int i = 0; i < IN_FIELDS; i++) s_axis_tdata[CB*i +: CB] <= f[i];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Predict at acceptance of each input beat.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      coords_t f;
      for (int i = 0; i < IN_FIELDS; i++) f[i] = s_axis_tdata[CB*i +: CB];
      normal_q.push_back(contact_normal(f));
    end
  end

  // Result side: field-by-field check and random stall bursts.
  initial begin
    int stall;
    logic [31:0] exp_w;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          exp_w = normal_q.pop_front();
          if (m_axis_tdata[0] !== exp_w[0]) begin
            $display("%0t: inside expected %b actual %b", $realtime, exp_w[0], m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[8:1] !== exp_w[8:1]) begin
            $display("%0t: normal_x expected %h actual %h", $realtime, exp_w[8:1],
                     m_axis_tdata[8:1]);
            errors++;
          end
          if (m_axis_tdata[16:9] !== exp_w[16:9]) begin
            $display("%0t: normal_y expected %h actual %h", $realtime, exp_w[16:9],
                     m_axis_tdata[16:9]);
            errors++;
          end
          if (m_axis_tdata[24:17] !== exp_w[24:17]) begin
            $display("%0t: normal_z expected %h actual %h", $realtime, exp_w[24:17],
                     m_axis_tdata[24:17]);
            errors++;
          end
          if (m_axis_tdata[31:25] !== exp_w[31:25]) begin
            $display("%0t: padding expected %h actual %h", $realtime, exp_w[31:25],
                     m_axis_tdata[31:25]);
            errors++;
          end
        end
      end
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 18);
      m_axis_tready <= !hold_off && stall == 0;
    end
  end

  // One long hold-off on the result side so the pipeline fills and stalls its input.
  initial begin
    wait (sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Typed rows check themselves; the others rely on the predictor.
  task automatic add_row(coords_t f, bit typed, logic [31:0] want);
    row_t r;
    r.f = f; r.typed = typed; r.want = want;
    rows.push_back(r);
  endtask

  initial begin
    coords_t f;
    logic [31:0] got;
    add_row('{default: 0}, 1, 32'h1);
    add_row('{default: 32767}, 1, 32'h1);
    add_row('{default: -32768}, 1, 32'h1);
    // All vertices equal: the edge tests tie at zero, so any point is inside.
    add_row('{-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767}, 1, 32'h1);
    // Point well away from a small triangle.
    add_row('{100, 100, 0, 0, 0, 10, 0, 0, 0, 0, 10}, 1, 32'h0);
    add_row('{0, 0, -32768, -32768, -32768, 32767, 32767, -32768,
              -32768, 32767, 32767}, 0, 0);
    add_row('{0, 0, -32768, -32768, -32768, -32768, 32767, 32767,
              32767, 32767, -32768}, 0, 0);
    add_row('{1, 1, 0, 0, 0, 0, 0, 10, 10, 0, 0}, 0, 0);
    add_row('{1, 1, 0, 0, 0, 10, 0, 0, 0, 0, 10}, 0, 0);
    add_row('{2, 2, 0, 5, 0, 0, -7, 10, 10, 3, 0}, 0, 0);
    // Triangle collinear in XZ with the point on the line.
    add_row('{5, 5, 0, 0, 0, 10, 40, 10, 20, -9, 20}, 0, 0);
    add_row('{-32768, 32767, -32768, 32767, 32767, 32767, -32768, -32768,
              -32768, 0, -32768}, 0, 0);
    add_row('{32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
              32767, -1, 32767}, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got = contact_normal(rows[i].f);
        if (got !== rows[i].want) begin
          $display("%0t: table row %0d expected %h predictor %h", $realtime, i,
                   rows[i].want, got);
          errors++;
        end
      end
      send_beat(rows[i].f);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - QUIET) quiet = 1'b1;
      f = random_triangle();
      send_beat(f);
    end
    s_axis_tvalid <= 1'b0;

    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12.0 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
